/* rtl/integer_set_table_assert.svh */
// ----------------------------------------------------------------------------
// integer_set_table assertion macros
// Concurrent assertion helpers for the set table; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef INTEGER_SET_TABLE_ASSERT_SVH
`define INTEGER_SET_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define IST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("integer_set_table: check failed");

// Next-cycle implication, disabled during reset
`define IST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("integer_set_table: check failed");

`else

`define IST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/ist_pkg.sv */
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants of the integer set table.
// ----------------------------------------------------------------------------
package ist_pkg;

	// Element word
	localparam int ELEM_W = 32;
	typedef logic signed [ELEM_W-1:0] elem_t;

	// Extremes reported for an empty set
	localparam elem_t TOP_VALUE    = 32'sh7FFF_FFFF;
	localparam elem_t BOTTOM_VALUE = 32'sh8000_0000;

	// Width of the reported element count
	localparam int COUNT_W = 5;

	// Operation codes
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_SHIFT  = 2'd2,
		ST_MINMAX = 2'd3
	} state_t;

endpackage

/* rtl/ist_ram.sv */
// ----------------------------------------------------------------------------
// ist_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ist_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  ist_pkg::elem_t wr_data,
	input  logic [AW-1:0] rd_addr,
	output ist_pkg::elem_t rd_data
);

	ist_pkg::elem_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; read data is registered
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/integer_set_table.sv */
// Operation: the single store read port is walked once to search, once to compact on a
//   remove, once for min/max; a transaction is accepted only while the table is idle.
// Flow: the next transaction is taken while a result waits, and a result not yet taken
//   stalls the end of the next min/max pass.
// Reset: arst_n empties the set at once; the store itself is not cleared.
// ----------------------------------------------------------------------------
// integer_set_table
// Set of distinct signed 32-bit values kept in an unordered compact store.
// ----------------------------------------------------------------------------
module integer_set_table #(
	parameter int CAPACITY = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      mode,
	input  logic signed [31:0]              value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic                            ok,
	output logic [ist_pkg::COUNT_W-1:0]     count,
	output logic signed [31:0]              min_value,
	output logic signed [31:0]              max_value
);

	`include "integer_set_table_assert.svh"

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	ist_pkg::state_t state_q, state_d;
	ist_pkg::mode_t  mode_q;
	ist_pkg::elem_t  value_q, lo_q, hi_q;
	ist_pkg::elem_t  rd_data_s1, wr_data;

	logic [CW-1:0] cnt_q, idx_q;
	logic [AW-1:0] pos_q, rd_idx_s1, wr_addr;
	logic          rd_vld_s1, found_q, ok_q, out_valid_q;
	logic          rd_issue, wr_en, hit, pass_end, scan_end, shift_end, load_out;
	logic          in_fire;

	logic                        res_found_q, res_ok_q;
	logic [ist_pkg::COUNT_W-1:0] res_count_q;
	ist_pkg::elem_t              res_min_q, res_max_q;
	logic [CW+ist_pkg::COUNT_W-1:0] cnt_ext;

	assign in_ready = (state_q == ist_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign cnt_ext  = {{ist_pkg::COUNT_W{1'b0}}, cnt_q};

	// Element store
	ist_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data_s1)
	);

	// Next state and store controls
	always_comb begin
		state_d   = state_q;
		rd_issue  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = rd_idx_s1 - AW'(1);
		wr_data   = rd_data_s1;
		scan_end  = 1'b0;
		shift_end = 1'b0;
		load_out  = 1'b0;
		pass_end  = !rd_vld_s1 && (idx_q >= cnt_q);
		hit       = (state_q == ist_pkg::ST_SCAN) && rd_vld_s1 && !found_q &&
			(rd_data_s1 == value_q);
		unique case (state_q)
			ist_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ist_pkg::ST_SCAN;
				end
			end
			ist_pkg::ST_SCAN: begin
				rd_issue = !found_q && !hit && (idx_q < cnt_q);
				if (!rd_vld_s1 && (found_q || (idx_q >= cnt_q))) begin
					scan_end = 1'b1;
					state_d  = ist_pkg::ST_MINMAX;
					if (mode_q == ist_pkg::MODE_INSERT && !found_q && cnt_q < CAP_C) begin
						wr_en   = 1'b1;
						wr_addr = cnt_q[AW-1:0];
						wr_data = value_q;
					end
					if (mode_q == ist_pkg::MODE_REMOVE && found_q) begin
						state_d = ist_pkg::ST_SHIFT;
					end
				end
			end
			ist_pkg::ST_SHIFT: begin
				rd_issue = (idx_q < cnt_q);
				wr_en    = rd_vld_s1;
				if (pass_end) begin
					shift_end = 1'b1;
					state_d   = ist_pkg::ST_MINMAX;
				end
			end
			ist_pkg::ST_MINMAX: begin
				rd_issue = (idx_q < cnt_q);
				if (pass_end && (!out_valid_q || out_ready)) begin
					load_out = 1'b1;
					state_d  = ist_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ist_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ist_pkg::ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			ok_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;

			// Advance the walk pointer
			if (rd_issue) begin
				idx_q <= idx_q + CW'(1);
			end

			// Start a new transaction
			if (in_fire) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				ok_q    <= 1'b1;
			end

			// Record the first match
			if (hit) begin
				found_q <= 1'b1;
			end

			// Apply the operation at the end of the search
			if (scan_end) begin
				idx_q <= (mode_q == ist_pkg::MODE_REMOVE && found_q) ?
					CW'(pos_q) + CW'(1) : '0;
				unique case (mode_q)
					ist_pkg::MODE_INSERT: begin
						if (!found_q) begin
							if (cnt_q < CAP_C) begin
								cnt_q <= cnt_q + CW'(1);
							end else begin
								ok_q <= 1'b0;
							end
						end
					end
					ist_pkg::MODE_CLEAR: begin
						cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end

			// Drop the removed entry once the tail is moved down
			if (shift_end) begin
				idx_q <= '0;
				cnt_q <= cnt_q - CW'(1);
			end

			// Hold the result until taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if (in_fire) begin
			mode_q  <= ist_pkg::mode_t'(mode);
			value_q <= value;
		end
		if (hit) begin
			pos_q <= rd_idx_s1;
		end
		// Reset extremes on entry to the min/max pass
		if (scan_end || shift_end) begin
			lo_q <= ist_pkg::TOP_VALUE;
			hi_q <= ist_pkg::BOTTOM_VALUE;
		end else if (state_q == ist_pkg::ST_MINMAX && rd_vld_s1) begin
			if (rd_data_s1 < lo_q) begin
				lo_q <= rd_data_s1;
			end
			if (rd_data_s1 > hi_q) begin
				hi_q <= rd_data_s1;
			end
		end
		if (load_out) begin
			res_found_q <= found_q;
			res_ok_q    <= ok_q;
			res_count_q <= cnt_ext[ist_pkg::COUNT_W-1:0];
			res_min_q   <= lo_q;
			res_max_q   <= hi_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = res_found_q;
	assign ok        = res_ok_q;
	assign count     = res_count_q;
	assign min_value = res_min_q;
	assign max_value = res_max_q;

	// Checks
	`IST_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP_C)
	`IST_ASSERT_NEXT(a_accept_scan, clk, arst_n, in_fire, state_q == ist_pkg::ST_SCAN)
	`IST_ASSERT_IMPL(a_read_busy, clk, arst_n, rd_vld_s1, state_q != ist_pkg::ST_IDLE)
	`IST_ASSERT_IMPL(a_write_bound, clk, arst_n, wr_en && state_q == ist_pkg::ST_SHIFT, CW'(wr_addr) < cnt_q)

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_set_table testbench
// Drives insert, remove, query and clear transactions into the set table with
// random idle gaps on both channels. A directed table covers the empty set,
// the signed extremes, duplicates, a compacting remove, a full store and a
// clear; a weighted random phase follows. Every result is checked field by
// field against its pinned expectation or else an in-bench model of the set.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SET_CAPACITY = 16;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_AT     = 600;
	localparam int POOL_SIZE    = 24;
	localparam int DIRECTED_ROWS = 24;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	// Largest and smallest element word
	localparam ist_pkg::elem_t TOP_V = ist_pkg::TOP_VALUE;
	localparam ist_pkg::elem_t BOT_V = ist_pkg::BOTTOM_VALUE;

	// One result of the set table
	typedef struct packed {
		logic                        found;
		logic                        ok;
		logic [ist_pkg::COUNT_W-1:0] count;
		ist_pkg::elem_t              min_value;
		ist_pkg::elem_t              max_value;
	} set_result_t;

	// One row of directed stimulus; the result is typed in only when pinned
	typedef struct packed {
		ist_pkg::mode_t op;
		ist_pkg::elem_t v;
		logic           pinned;
		set_result_t    want;
	} stim_row_t;

	localparam set_result_t NO_WANT = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = ist_pkg::MODE_QUERY;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic ok;
	logic [ist_pkg::COUNT_W-1:0] count;
	logic signed [31:0] min_value;
	logic signed [31:0] max_value;

	// Pinned expectation travels with the payload
	logic        item_pinned = 1'b0;
	set_result_t item_want = '0;

	// Model of the set
	ist_pkg::elem_t set_store [SET_CAPACITY];
	int             set_count = 0;
	set_result_t    pending_results [$];

	int  errors = 0;
	int  cycle_count = 0;
	int  stall_left = 0;
	bit  calm_phase = 1'b0;
	ist_pkg::elem_t value_pool [POOL_SIZE];

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ist_pkg::MODE_QUERY,  32'sd0,  1'b1, '{1'b0, 1'b1, 5'd0, TOP_V, BOT_V}},
		'{ist_pkg::MODE_REMOVE, 32'sd5,  1'b1, '{1'b0, 1'b1, 5'd0, TOP_V, BOT_V}},
		'{ist_pkg::MODE_INSERT, BOT_V,   1'b1, '{1'b0, 1'b1, 5'd1, BOT_V, BOT_V}},
		'{ist_pkg::MODE_INSERT, TOP_V,   1'b1, '{1'b0, 1'b1, 5'd2, BOT_V, TOP_V}},
		'{ist_pkg::MODE_INSERT, BOT_V,   1'b1, '{1'b1, 1'b1, 5'd2, BOT_V, TOP_V}},
		'{ist_pkg::MODE_QUERY,  TOP_V,   1'b1, '{1'b1, 1'b1, 5'd2, BOT_V, TOP_V}},
		'{ist_pkg::MODE_REMOVE, BOT_V,   1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, -32'sd7, 1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, -32'sd6, 1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, -32'sd5, 1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, -32'sd4, 1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, -32'sd3, 1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, -32'sd2, 1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, -32'sd1, 1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd0,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd1,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd2,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd3,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd4,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd5,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd6,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd7,  1'b0, NO_WANT},
		'{ist_pkg::MODE_INSERT, 32'sd100, 1'b1, '{1'b0, 1'b0, 5'd16, -32'sd7, TOP_V}},
		'{ist_pkg::MODE_CLEAR,  32'sd3,  1'b1, '{1'b1, 1'b1, 5'd0, TOP_V, BOT_V}}
	};

	integer_set_table #(
		.CAPACITY (SET_CAPACITY)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.ok        (ok),
		.count     (count),
		.min_value (min_value),
		.max_value (max_value)
	);

	always #5 clk = ~clk;

	// Apply one operation to the model set and return what the table reports
	function automatic set_result_t apply_set_op(ist_pkg::mode_t op, ist_pkg::elem_t v);
		set_result_t r;
		int pos;
		int i;
		pos = set_count;
		for (i = 0; i < set_count; i++) begin
			if (pos == set_count && set_store[i] == v)
				pos = i;
		end
		r.found = (pos < set_count);
		r.ok = 1'b1;
		case (op)
			ist_pkg::MODE_INSERT: begin
				if (!r.found) begin
					if (set_count >= SET_CAPACITY) begin
						r.ok = 1'b0;
					end else begin
						set_store[set_count] = v;
						set_count++;
					end
				end
			end
			ist_pkg::MODE_REMOVE: begin
				// close the gap left by the removed entry
				if (r.found) begin
					for (i = pos; i + 1 < set_count; i++)
						set_store[i] = set_store[i + 1];
					set_count--;
				end
			end
			ist_pkg::MODE_CLEAR: begin
				set_count = 0;
			end
			default: ;
		endcase
		r.min_value = ist_pkg::TOP_VALUE;
		r.max_value = ist_pkg::BOTTOM_VALUE;
		for (i = 0; i < set_count; i++) begin
			if (set_store[i] < r.min_value)
				r.min_value = set_store[i];
			if (set_store[i] > r.max_value)
				r.max_value = set_store[i];
		end
		r.count = set_count[ist_pkg::COUNT_W-1:0];
		return r;
	endfunction

	// Offer one transaction after a random gap; optionally drain first
	task automatic send_transaction(input ist_pkg::mode_t op, input ist_pkg::elem_t v,
			input logic pinned, input set_result_t want, input bit drain);
		int gap;
		gap = calm_phase ? 0 : $urandom_range(0, 12);
		if (gap > 0 || drain) begin
			in_valid <= 1'b0;
			if (drain) begin
				do @(posedge clk); while (pending_results.size() != 0);
			end
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		value <= v;
		item_pinned <= pinned;
		item_want <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold off the result channel for a random number of cycles per result
	always @(posedge clk) begin
		if (out_valid && out_ready)
			stall_left = calm_phase ? 0 : $urandom_range(0, 12);
		else if (stall_left > 0)
			stall_left--;
		out_ready <= (stall_left == 0);
	end

	// Check each accepted result, then record each accepted transaction
	always @(posedge clk) begin : result_check
		set_result_t want_r;
		set_result_t model_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction pending", $time);
				errors++;
			end else begin
				want_r = pending_results.pop_front();
				if (found !== want_r.found) begin
					$display("%0t: found expected %0b actual %0b", $time, want_r.found, found);
					errors++;
				end
				if (ok !== want_r.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, want_r.ok, ok);
					errors++;
				end
				if (count !== want_r.count) begin
					$display("%0t: count expected %0d actual %0d", $time, want_r.count, count);
					errors++;
				end
				if (min_value !== want_r.min_value) begin
					$display("%0t: min_value expected %0d actual %0d", $time,
						want_r.min_value, min_value);
					errors++;
				end
				if (max_value !== want_r.max_value) begin
					$display("%0t: max_value expected %0d actual %0d", $time,
						want_r.max_value, max_value);
					errors++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			model_r = apply_set_op(ist_pkg::mode_t'(mode), value);
			pending_results.push_back(item_pinned ? item_want : model_r);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Reset, directed table, weighted random phase, drain and report
	initial begin
		int k;
		int pick;
		int phase;
		ist_pkg::mode_t rop;
		ist_pkg::elem_t rv;
		arst_n = 1'b0;
		value_pool[0] = ist_pkg::BOTTOM_VALUE;
		value_pool[1] = ist_pkg::TOP_VALUE;
		value_pool[2] = '0;
		value_pool[3] = -32'sd1;
		for (k = 4; k < POOL_SIZE; k++)
			value_pool[k] = ist_pkg::elem_t'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIRECTED_ROWS; k++)
			send_transaction(directed_rows[k].op, directed_rows[k].v,
				directed_rows[k].pinned, directed_rows[k].want, 1'b0);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			// rotate between growing, balanced and shrinking mixes
			phase = (k / 150) % 3;
			calm_phase = ((k / 100) % 4 == 3);
			pick = $urandom_range(0, 99);
			case (phase)
				0: rop = pick < 60 ? ist_pkg::MODE_INSERT : pick < 75 ? ist_pkg::MODE_REMOVE :
					pick < 95 ? ist_pkg::MODE_QUERY : ist_pkg::MODE_CLEAR;
				1: rop = pick < 35 ? ist_pkg::MODE_INSERT : pick < 65 ? ist_pkg::MODE_REMOVE :
					pick < 95 ? ist_pkg::MODE_QUERY : ist_pkg::MODE_CLEAR;
				default: rop = pick < 25 ? ist_pkg::MODE_INSERT :
					pick < 70 ? ist_pkg::MODE_REMOVE :
					pick < 97 ? ist_pkg::MODE_QUERY : ist_pkg::MODE_CLEAR;
			endcase
			// mostly reuse pooled values so that hits and duplicates are common
			if ($urandom_range(0, 3) != 0)
				rv = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				rv = ist_pkg::elem_t'($urandom);
			send_transaction(rop, rv, 1'b0, NO_WANT, k == DRAIN_AT);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_ram.sv
rtl/integer_set_table.sv
verif/testbench.sv
